// File: hw/rtl/ajtm_pkg.sv
// shared types and constants for the arrival jitter trimmed mean block
`default_nettype none

package ajtm_pkg;

  // field widths
  localparam int TIME_W   = 32;
  localparam int CFG_W    = 16;
  localparam int EXC_W    = 14;
  localparam int MEAN_W   = 17;

  // defaults and limits
  localparam int WINDOW_DEF = 10;
  localparam logic [CFG_W-1:0] INTERVAL_RESET = 16'd10;
  localparam logic [EXC_W-1:0] EXCESS_MAX     = 14'd16383;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXC,
    ST_SCAN,
    ST_DRAIN,
    ST_KEEP,
    ST_MUL,
    ST_FIN,
    ST_DONE
  } state_t;

  // control from the sequencer to the ring storage
  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic acc_clear;
  } ring_ctl_t;

endpackage

`default_nettype wire

// File: hw/rtl/ajtm_ring.sv
// delay ring memory with a scanning sum, max and min accumulator
`default_nettype none

module ajtm_ring #(
  parameter int WINDOW = ajtm_pkg::WINDOW_DEF,
  localparam int PTR_W = $clog2(WINDOW),
  localparam int SUM_W = ajtm_pkg::EXC_W + $clog2(WINDOW)
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire ajtm_pkg::ring_ctl_t       ctl,
  input  wire logic [PTR_W-1:0]          wr_addr,
  input  wire logic [ajtm_pkg::EXC_W-1:0] wr_data,
  input  wire logic [PTR_W-1:0]          rd_addr,
  output logic [SUM_W-1:0]               sum,
  output logic [ajtm_pkg::EXC_W-1:0]     hi,
  output logic [ajtm_pkg::EXC_W-1:0]     lo
);

  logic [ajtm_pkg::EXC_W-1:0] mem [WINDOW];
  logic [ajtm_pkg::EXC_W-1:0] rd_data_r;
  logic                       acc_en_r;
  logic [SUM_W-1:0]           sum_r;
  logic [ajtm_pkg::EXC_W-1:0] hi_r;
  logic [ajtm_pkg::EXC_W-1:0] lo_r;

  // single write port, registered read port
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // read data arrives in the cycle after the read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_en_r <= 1'b0;
    end else begin
      acc_en_r <= ctl.rd_en;
    end
  end

  // running sum, max and min over the scanned entries
  always_ff @(posedge clk) begin
    if (ctl.acc_clear) begin
      sum_r <= '0;
      hi_r  <= '0;
      lo_r  <= ajtm_pkg::EXCESS_MAX;
    end else if (acc_en_r) begin
      sum_r <= sum_r + SUM_W'(rd_data_r);
      if (rd_data_r > hi_r) begin
        hi_r <= rd_data_r;
      end
      if (rd_data_r < lo_r) begin
        lo_r <= rd_data_r;
      end
    end
  end

  assign sum = sum_r;
  assign hi  = hi_r;
  assign lo  = lo_r;

endmodule

`default_nettype wire

// File: hw/rtl/arrival_jitter_trimmed_mean_core.sv
// top level: report gap measurement, delay ring and trimmed mean sequencer
//
// Input words carry a millisecond arrival time and a position report flag;
// each accepted input word yields exactly one output word. The nominal
// report interval is written through cfg_wr_en / cfg_wr_data (reset 10 ms).
// The first report after reset only stores its time. Later reports give
// the gap minus the interval, floored at zero and clipped to 16383; a
// positive value is written into a WINDOW-entry ring memory. Once the ring
// is full, each further write also gives the mean of the ring without one
// maximum and one minimum, in eighths of a millisecond.
// Ignored and first reports go from idle straight to the done state; a
// report that gives no mean first passes the excess state, and one that
// does also passes the scan, drain, keep, multiply and finish states. The
// next word is taken when the sequencer is back in idle. The scan reads one
// ring entry per cycle through the single memory read port; a mean is the long
// case. One word is in work at a time; in_ready is high while the sequencer
// is idle, even if the previous result still sits in the output register.
// If the receiver stalls, the finished word waits in the sequencer until
// the output register frees up. Reset clears the ring fill state and the
// start flag and sets the interval to 10 ms; ring contents need no clearing.
`default_nettype none

module arrival_jitter_trimmed_mean_core #(
  parameter int WINDOW = ajtm_pkg::WINDOW_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // configuration
  input  wire logic                         cfg_wr_en,
  input  wire logic [ajtm_pkg::CFG_W-1:0]   cfg_wr_data,
  // input channel
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [ajtm_pkg::TIME_W-1:0]  in_arrival_time_ms,
  input  wire logic                         in_is_position_report,
  // output channel
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [ajtm_pkg::EXC_W-1:0]        out_excess_delay_ms,
  output logic                              out_pushed,
  output logic                              out_mean_valid,
  output logic [ajtm_pkg::MEAN_W-1:0]       out_mean_delay_eighths
);

  localparam int TIME_W  = ajtm_pkg::TIME_W;
  localparam int CFG_W   = ajtm_pkg::CFG_W;
  localparam int EXC_W   = ajtm_pkg::EXC_W;
  localparam int MEAN_W  = ajtm_pkg::MEAN_W;
  localparam int PTR_W   = $clog2(WINDOW);
  localparam int FILL_W  = $clog2(WINDOW + 1);
  localparam int SUM_W   = EXC_W + $clog2(WINDOW);
  localparam int NUM_W   = SUM_W + 3;
  localparam int DIV_D   = WINDOW - 2;
  localparam int DIV_SH  = NUM_W + $clog2(DIV_D);
  localparam int RECIP_W = DIV_SH + 1;
  localparam int PROD_W  = NUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << DIV_SH) + 64'(DIV_D) - 64'd1) / 64'(DIV_D));
  localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(WINDOW - 1);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW);

  ajtm_pkg::state_t state_r, state_nxt;

  logic [CFG_W-1:0]  interval_r;
  logic              started_r, started_nxt;
  logic [TIME_W-1:0] last_r, last_nxt;
  logic [TIME_W-1:0] gap_r, gap_nxt;
  logic [PTR_W-1:0]  ptr_r, ptr_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [PTR_W-1:0]  scan_idx_r, scan_idx_nxt;
  logic [NUM_W-1:0]  num_r, num_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;

  // pending result of the word in work
  logic [EXC_W-1:0]  excess_r, excess_nxt;
  logic              pushed_r, pushed_nxt;
  logic              mvalid_r, mvalid_nxt;
  logic [MEAN_W-1:0] mean_r, mean_nxt;

  // output register
  logic              out_valid_r;
  logic [EXC_W-1:0]  out_excess_r;
  logic              out_pushed_r;
  logic              out_mvalid_r;
  logic [MEAN_W-1:0] out_mean_r;
  logic              out_load;

  ajtm_pkg::ring_ctl_t ring_ctl;
  logic [SUM_W-1:0]    ring_sum;
  logic [EXC_W-1:0]    ring_hi;
  logic [EXC_W-1:0]    ring_lo;

  logic [TIME_W:0]   diff;
  logic              push_c;
  logic [EXC_W-1:0]  excess_c;
  logic [SUM_W-1:0]  kept_c;
  logic              in_fire;

  assign in_fire = in_valid && in_ready;

  // gap minus interval, floor and clip
  assign diff     = {1'b0, gap_r} - {{(TIME_W + 1 - CFG_W){1'b0}}, interval_r};
  assign push_c   = !diff[TIME_W] && (diff[TIME_W-1:0] != '0);
  assign excess_c = (|diff[TIME_W-1:EXC_W]) ? ajtm_pkg::EXCESS_MAX : diff[EXC_W-1:0];

  // ring sum without one max and one min
  assign kept_c = ring_sum - SUM_W'(ring_hi) - SUM_W'(ring_lo);

  ajtm_ring #(
    .WINDOW (WINDOW)
  ) u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ring_ctl),
    .wr_addr (ptr_r),
    .wr_data (excess_c),
    .rd_addr (scan_idx_r),
    .sum     (ring_sum),
    .hi      (ring_hi),
    .lo      (ring_lo)
  );

  // state register and control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ajtm_pkg::ST_IDLE;
      interval_r <= ajtm_pkg::INTERVAL_RESET;
      started_r  <= 1'b0;
      last_r     <= '0;
      ptr_r      <= '0;
      fill_r     <= '0;
      scan_idx_r <= '0;
    end else begin
      state_r    <= state_nxt;
      started_r  <= started_nxt;
      last_r     <= last_nxt;
      ptr_r      <= ptr_nxt;
      fill_r     <= fill_nxt;
      scan_idx_r <= scan_idx_nxt;
      if (cfg_wr_en) begin
        interval_r <= cfg_wr_data;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    gap_r    <= gap_nxt;
    num_r    <= num_nxt;
    prod_r   <= prod_nxt;
    excess_r <= excess_nxt;
    pushed_r <= pushed_nxt;
    mvalid_r <= mvalid_nxt;
    mean_r   <= mean_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    started_nxt  = started_r;
    last_nxt     = last_r;
    gap_nxt      = gap_r;
    ptr_nxt      = ptr_r;
    fill_nxt     = fill_r;
    scan_idx_nxt = scan_idx_r;
    num_nxt      = num_r;
    prod_nxt     = prod_r;
    excess_nxt   = excess_r;
    pushed_nxt   = pushed_r;
    mvalid_nxt   = mvalid_r;
    mean_nxt     = mean_r;
    ring_ctl     = '0;
    in_ready     = 1'b0;
    out_load     = 1'b0;

    case (state_r)
      ajtm_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        excess_nxt = '0;
        pushed_nxt = 1'b0;
        mvalid_nxt = 1'b0;
        mean_nxt   = '0;
        if (in_fire) begin
          if (in_is_position_report) begin
            last_nxt    = in_arrival_time_ms;
            started_nxt = 1'b1;
            if (started_r) begin
              gap_nxt   = in_arrival_time_ms - last_r;
              state_nxt = ajtm_pkg::ST_EXC;
            end else begin
              state_nxt = ajtm_pkg::ST_DONE;
            end
          end else begin
            state_nxt = ajtm_pkg::ST_DONE;
          end
        end
      end

      ajtm_pkg::ST_EXC: begin
        state_nxt = ajtm_pkg::ST_DONE;
        if (push_c) begin
          excess_nxt     = excess_c;
          pushed_nxt     = 1'b1;
          ring_ctl.wr_en = 1'b1;
          ptr_nxt        = (ptr_r == PTR_LAST) ? '0 : ptr_r + 1'b1;
          if (fill_r == FILL_FULL) begin
            ring_ctl.acc_clear = 1'b1;
            scan_idx_nxt       = '0;
            state_nxt          = ajtm_pkg::ST_SCAN;
          end else begin
            fill_nxt = fill_r + 1'b1;
          end
        end
      end

      // one ring read per cycle
      ajtm_pkg::ST_SCAN: begin
        ring_ctl.rd_en = 1'b1;
        if (scan_idx_r == PTR_LAST) begin
          state_nxt = ajtm_pkg::ST_DRAIN;
        end else begin
          scan_idx_nxt = scan_idx_r + 1'b1;
        end
      end

      // last read word enters the accumulator
      ajtm_pkg::ST_DRAIN: begin
        state_nxt = ajtm_pkg::ST_KEEP;
      end

      ajtm_pkg::ST_KEEP: begin
        num_nxt   = {kept_c, 3'b000};
        state_nxt = ajtm_pkg::ST_MUL;
      end

      // divide by WINDOW-2 through a reciprocal multiply
      ajtm_pkg::ST_MUL: begin
        prod_nxt  = PROD_W'(num_r) * PROD_W'(RECIP);
        state_nxt = ajtm_pkg::ST_FIN;
      end

      ajtm_pkg::ST_FIN: begin
        mean_nxt   = prod_r[DIV_SH +: MEAN_W];
        mvalid_nxt = 1'b1;
        state_nxt  = ajtm_pkg::ST_DONE;
      end

      // hand the word to the output register when it is free
      ajtm_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ajtm_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = ajtm_pkg::ST_IDLE;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_excess_r <= excess_r;
      out_pushed_r <= pushed_r;
      out_mvalid_r <= mvalid_r;
      out_mean_r   <= mean_r;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_excess_delay_ms    = out_excess_r;
  assign out_pushed             = out_pushed_r;
  assign out_mean_valid         = out_mvalid_r;
  assign out_mean_delay_eighths = out_mean_r;

  // a mean only comes with a ring write
  a_mean_needs_push: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_mean_valid |-> out_pushed)
    else $error("mean given without a ring write");

  // a word without a ring write carries no delay and no mean
  a_no_push_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_pushed |-> (out_excess_delay_ms == '0) &&
                                 (out_mean_delay_eighths == '0))
    else $error("nonzero fields on a word without a ring write");

  // fill count and write pointer stay within the ring
  a_ring_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r <= FILL_FULL) && (ptr_r <= PTR_LAST))
    else $error("ring fill count or pointer out of range");

  // the pointer follows the fill count until the ring has filled once
  a_ptr_tracks_fill: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r != FILL_FULL |-> ptr_r == PTR_W'(fill_r))
    else $error("ring pointer and fill count disagree");

  // one word in work at a time
  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("second word accepted while one is in work");

endmodule

`default_nettype wire
